// ----- design/lppr_pkg.sv -----
// ----------------------------------------------------------------------------
// lppr_pkg
// shared constants, codes and the per-channel predictor for the pixel
// prediction residual core
// ----------------------------------------------------------------------------
package lppr_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int SAMPLE_W   = 8;
  localparam int PIXEL_W    = 3 * SAMPLE_W;
  localparam int MODE_W     = 4;
  localparam int IMG_W_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREDICTOR_SELECT = 1'b0,
    REG_IMAGE_WIDTH      = 1'b1
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    PRED_RAW    = 4'd0,
    PRED_W      = 4'd1,
    PRED_N      = 4'd2,
    PRED_NW     = 4'd3,
    PRED_PLANE  = 4'd4,
    PRED_N_HALF = 4'd5,
    PRED_W_HALF = 4'd6,
    PRED_AVG    = 4'd7,
    PRED_MED    = 4'd8
  } pred_t;

  // prediction modulo 256; halving truncates toward zero
  function automatic logic [SAMPLE_W-1:0] predict(
    input logic [MODE_W-1:0]   mode,
    input logic [SAMPLE_W-1:0] w,
    input logic [SAMPLE_W-1:0] n,
    input logic [SAMPLE_W-1:0] nw
  );
    logic signed [9:0]  sw;
    logic signed [9:0]  sn;
    logic signed [9:0]  snw;
    logic signed [9:0]  dwn;
    logic signed [9:0]  dnw;
    logic signed [9:0]  hwn;
    logic signed [9:0]  hnw;
    logic signed [10:0] p;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    sw  = $signed({2'b00, w});
    sn  = $signed({2'b00, n});
    snw = $signed({2'b00, nw});
    dwn = sw - snw;
    dnw = sn - snw;
    hwn = (dwn + $signed({9'b0, dwn[9]})) >>> 1;
    hnw = (dnw + $signed({9'b0, dnw[9]})) >>> 1;
    lo  = (w < n) ? w : n;
    hi  = (w < n) ? n : w;
    unique case (mode)
      PRED_W:      p = 11'(sw);
      PRED_N:      p = 11'(sn);
      PRED_NW:     p = 11'(snw);
      PRED_PLANE:  p = 11'(sn) + 11'(sw) - 11'(snw);
      PRED_N_HALF: p = 11'(sn) + 11'(hwn);
      PRED_W_HALF: p = 11'(sw) + 11'(hnw);
      PRED_AVG:    p = (11'(sn) + 11'(sw)) >>> 1;
      PRED_MED: begin
        if (nw >= hi) begin
          p = $signed({3'b000, lo});
        end else if (nw <= lo) begin
          p = $signed({3'b000, hi});
        end else begin
          p = 11'(sw) + 11'(sn) - 11'(snw);
        end
      end
      default:     p = '0;
    endcase
    return p[SAMPLE_W-1:0];
  endfunction

endpackage

// ----- design/lppr_if.sv -----
// ----------------------------------------------------------------------------
// lppr_pix_if / lppr_res_if
// valid/ready channels for incoming pixels and outgoing residuals
// ----------------------------------------------------------------------------
interface lppr_pix_if;
  logic                          valid;
  logic                          ready;
  logic [lppr_pkg::SAMPLE_W-1:0] pixel_blue;
  logic [lppr_pkg::SAMPLE_W-1:0] pixel_green;
  logic [lppr_pkg::SAMPLE_W-1:0] pixel_red;
  logic                          frame_start;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, frame_start,
                  input ready);
  modport sink   (input valid, pixel_blue, pixel_green, pixel_red, frame_start,
                  output ready);
endinterface

interface lppr_res_if;
  logic                          valid;
  logic                          ready;
  logic [lppr_pkg::SAMPLE_W-1:0] residual_blue;
  logic [lppr_pkg::SAMPLE_W-1:0] residual_green;
  logic [lppr_pkg::SAMPLE_W-1:0] residual_red;

  modport source (output valid, residual_blue, residual_green, residual_red,
                  input ready);
  modport sink   (input valid, residual_blue, residual_green, residual_red,
                  output ready);
endinterface

// ----- design/lppr_ram.sv -----
// ----------------------------------------------------------------------------
// lppr_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module lppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/lossless_pixel_prediction_residual_core.sv -----
// ----------------------------------------------------------------------------
// lossless_pixel_prediction_residual_core
// per-channel prediction residuals of an rgb raster stream, with a line
// store for the row above and registers for the west and northwest pixels
//
//   channel | dir | handshake    | payload
//   pix     | in  | valid/ready  | pixel_blue/green/red, frame_start
//   res     | out | valid/ready  | residual_blue/green/red
//   cfg     | in  | cfg_we       | cfg_index, cfg_data
//
// one pixel per clock while the result stage can move; a pixel passes the
// line store read, then the result register, before its residual appears
// the line store has one write and one read port, both used on every pixel
// reset is synchronous; the line store is not cleared, first row reads zero
// a stalled result holds; input stays open while the result stage can move
// ----------------------------------------------------------------------------
module lossless_pixel_prediction_residual_core #(
  parameter int MAX_WIDTH = lppr_pkg::MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  lppr_pix_if.sink                         pix,
  lppr_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [lppr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lppr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = (AW + 1 > lppr_pkg::IMG_W_W) ? AW + 1 : lppr_pkg::IMG_W_W;
  localparam int SW = lppr_pkg::SAMPLE_W;
  localparam int PW = lppr_pkg::PIXEL_W;

  logic [lppr_pkg::MODE_W-1:0]  predictor_select;
  logic [lppr_pkg::IMG_W_W-1:0] row_width;

  logic [AW-1:0] col;
  logic          top;
  logic [AW-1:0] col_next;
  logic          top_next;

  logic          v1;
  logic [PW-1:0] x1;
  logic          top1;
  logic          first1;
  logic [PW-1:0] n_raw;
  logic [PW-1:0] west;
  logic [PW-1:0] northwest;

  logic          ovalid;
  logic [SW-1:0] res_b;
  logic [SW-1:0] res_g;
  logic [SW-1:0] res_r;

  logic          accept;
  logic          adv1;
  logic [XW-1:0] eff;
  logic [XW-1:0] iw_x;
  logic [AW-1:0] col_a;
  logic          top_a;
  logic [AW-1:0] cur;
  logic          top_b;
  logic [AW:0]   col_inc;
  logic [PW-1:0] x_in;
  logic [PW-1:0] w_s;
  logic [PW-1:0] n_s;
  logic [PW-1:0] nw_s;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_select <= lppr_pkg::PRED_RAW;
      row_width        <= lppr_pkg::IMG_W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lppr_pkg::REG_PREDICTOR_SELECT:
          predictor_select <= cfg_data[lppr_pkg::MODE_W-1:0];
        lppr_pkg::REG_IMAGE_WIDTH:
          row_width <= cfg_data[lppr_pkg::IMG_W_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv1      = v1 && (!ovalid || res.ready);
  assign pix.ready = !v1 || adv1;
  assign accept    = pix.valid && pix.ready;
  assign x_in      = {pix.pixel_red, pix.pixel_green, pix.pixel_blue};

  // column and row tracking
  always_comb begin
    iw_x = XW'(row_width);
    if (row_width == '0) begin
      eff = XW'(1);
    end else if (iw_x > XW'(MAX_WIDTH)) begin
      eff = XW'(MAX_WIDTH);
    end else begin
      eff = iw_x;
    end
    col_a = pix.frame_start ? '0 : col;
    top_a = pix.frame_start ? 1'b1 : top;
    if (XW'(col_a) >= eff) begin
      cur   = '0;
      top_b = 1'b0;
    end else begin
      cur   = col_a;
      top_b = top_a;
    end
    col_inc = {1'b0, cur} + (AW+1)'(1);
    if (XW'(col_inc) >= eff) begin
      col_next = '0;
      top_next = 1'b0;
    end else begin
      col_next = col_inc[AW-1:0];
      top_next = top_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      top <= 1'b1;
    end else if (accept) begin
      col <= col_next;
      top <= top_next;
    end
  end

  lppr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (cur),
    .wdata (x_in),
    .re    (accept),
    .raddr (cur),
    .rdata (n_raw)
  );

  // neighbor stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1     <= x_in;
      top1   <= top_b;
      first1 <= (cur == '0);
    end
  end

  assign w_s  = first1 ? '0 : west;
  assign n_s  = top1 ? '0 : n_raw;
  assign nw_s = (top1 || first1) ? '0 : northwest;

  always_ff @(posedge clk) begin
    if (rst) begin
      west      <= '0;
      northwest <= '0;
    end else if (adv1) begin
      west      <= x1;
      northwest <= n_s;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv1) begin
      ovalid <= 1'b1;
    end else if (res.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      res_b <= x1[SW-1:0] - lppr_pkg::predict(predictor_select,
                 w_s[SW-1:0], n_s[SW-1:0], nw_s[SW-1:0]);
      res_g <= x1[2*SW-1:SW] - lppr_pkg::predict(predictor_select,
                 w_s[2*SW-1:SW], n_s[2*SW-1:SW], nw_s[2*SW-1:SW]);
      res_r <= x1[3*SW-1:2*SW] - lppr_pkg::predict(predictor_select,
                 w_s[3*SW-1:2*SW], n_s[3*SW-1:2*SW], nw_s[3*SW-1:2*SW]);
    end
  end

  assign res.valid          = ovalid;
  assign res.residual_blue  = res_b;
  assign res.residual_green = res_g;
  assign res.residual_red   = res_r;

endmodule

// ----- design/lppr_checker.sv -----
// ----------------------------------------------------------------------------
// lppr_checker
// port-level checks on the pixel prediction residual core, bound to the top
// ----------------------------------------------------------------------------
module lppr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lppr_pkg::SAMPLE_W-1:0] out_blue,
  input logic [lppr_pkg::SAMPLE_W-1:0] out_green,
  input logic [lppr_pkg::SAMPLE_W-1:0] out_red
);

  logic [2:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 3'd1;
    end else if (out_acc && !in_acc && inflight != '0) begin
      inflight <= inflight - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_blue) && $stable(out_green)
                                && $stable(out_red))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result without a pixel");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd2)
    else $error("more pixels held than the two stages");

endmodule

bind lossless_pixel_prediction_residual_core lppr_checker u_lppr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_blue  (res.residual_blue),
  .out_green (res.residual_green),
  .out_red   (res.residual_red)
);
